[hdl/quaternion_to_rotation_matrix_top_macros.svh]
// Assertion helpers for the quaternion to rotation matrix block.
// Clock i_clk and reset i_rst_n must be in scope where these are used.
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrm assertion failed");
// next-cycle implication
`define QRM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrm assertion failed");
`else
`define QRM_ASSERT_IMP(label, ante, cons)
`define QRM_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hdl/qrm_pkg.sv]
package qrm_pkg;

    // fixed count of Newton steps on the inverse square root
    localparam int NEWTON_STEPS = 7;

    // Newton seed 1.5 and constant 3.0, both Q2.30
    localparam logic [31:0] SEED_Q30  = 32'd1610612736;
    localparam logic [32:0] THREE_Q30 = 33'd3221225472;

    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [65:0] ONE_Q60   = 66'sh1000_0000_0000_0000;
    localparam logic signed [65:0] HALF_Q46  = 66'sh2000_0000_0000;
    localparam logic signed [19:0] SAT_HI    = 20'sd32767;
    localparam logic signed [19:0] SAT_LO    = -20'sd32768;

    // quaternion and normalization data carried down the pipe
    typedef struct packed {
        logic [3:0][15:0] q;
        logic             ident;
        logic [4:0]       sh;
        logic [31:0]      m;
    } t_carry;

    // round a Q60 value to Q2.14 (half up) and clamp
    function automatic logic signed [15:0] round_sat(input logic signed [65:0] v);
        logic signed [65:0] t;
        logic signed [19:0] r;
        t = v + HALF_Q46;
        r = 20'(t >>> 46);
        if (r > SAT_HI) begin
            return 16'(SAT_HI);
        end else if (r < SAT_LO) begin
            return 16'(SAT_LO);
        end
        return 16'(r);
    endfunction

endpackage

[hdl/quaternion_to_rotation_matrix_top.sv]
// Channel   Dir  Payload
// s_axis    in   tdata = quat_x, quat_y, quat_z, quat_w (16 bits each)
// m_axis    out  tdata = nine matrix entries row-major; tuser = used_identity
// cfg       in   i_cfg_we / i_cfg_wdata = length_tolerance
//
// One quaternion per cycle unless the full pipe is stalled by the output;
// 9 + 3*NEWTON_STEPS register stages (30 with seven steps).
// Each Newton step takes three stages, one multiplier each.
// Each stage advances when it is empty or the stage after it advances, so
// empty stages keep filling while the output transaction waits.
// Reset (synchronous, active low) empties the pipe and clears the tolerance.
module quaternion_to_rotation_matrix_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // row0_col0, row0_col1 ... row2_col2
    output logic         m_axis_tuser    // used_identity
);

`include "quaternion_to_rotation_matrix_top_macros.svh"

    localparam int NEWTON_STEPS = qrm_pkg::NEWTON_STEPS;
    localparam int ST_NEWT = 4;
    localparam int ST_NMUL = ST_NEWT + 3 * NEWTON_STEPS;
    localparam int ST_NSH  = ST_NMUL + 1;
    localparam int ST_PROD = ST_NMUL + 2;
    localparam int ST_SUM  = ST_NMUL + 3;
    localparam int ST_OUT  = ST_NMUL + 4;
    localparam int NS      = ST_OUT + 1;

    logic [31:0]   r_tol;
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_vin;
    logic [NS:0]   w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage ready chain: advance when empty or when the next stage advances
    always_comb begin
        w_en[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_vin = {r_v[NS-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_v[NS-1];

    // stage 0: squares
    logic [3:0][15:0] r_q0;
    logic [30:0]      r_sq [4];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_q0 <= s_axis_tdata;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= 31'($signed(s_axis_tdata[16*i +: 16]) *
                               $signed(s_axis_tdata[16*i +: 16]));
            end
        end
    end

    // stage 1: squared length and tolerance compare
    logic [3:0][15:0] r_q1;
    logic [32:0]      r_len;
    logic             r_id1;
    logic [32:0]      w_len;

    assign w_len = 33'(r_sq[0]) + 33'(r_sq[1]) + 33'(r_sq[2]) + 33'(r_sq[3]);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_q1  <= r_q0;
            r_len <= w_len;
            r_id1 <= (w_len <= {1'b0, r_tol});
        end
    end

    // stage 2: leading one position
    logic [3:0][15:0] r_q2;
    logic [32:0]      r_len2;
    logic             r_id2;
    logic [4:0]       r_p;
    logic [4:0]       w_p;

    always_comb begin
        w_p = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_len[b]) begin
                w_p = 5'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_q2   <= r_q1;
            r_len2 <= r_len;
            r_id2  <= r_id1;
            r_p    <= w_p;
        end
    end

    // stage 3: even shift into [2^30, 2^32)
    qrm_pkg::t_carry r_car [3:ST_NMUL];
    logic [3:0]      w_k;
    logic [31:0]     w_m;
    logic [4:0]      w_sh;

    always_comb begin
        w_k = 4'((5'd31 - r_p) >> 1);
        if (r_len2[32]) begin
            w_m  = {1'b0, r_len2[32:2]};
            w_sh = 5'd17;
        end else begin
            w_m  = r_len2[31:0] << {w_k, 1'b0};
            w_sh = 5'd16 - {1'b0, w_k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_car[3].q     <= r_q2;
            r_car[3].ident <= r_id2;
            r_car[3].sh    <= w_sh;
            r_car[3].m     <= w_m;
        end
    end

    for (genvar k = 4; k <= ST_NMUL; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_car[k] <= r_car[k-1];
            end
        end
    end

    // Newton steps on the inverse square root, three stages each
    logic [31:0] r_ya [NEWTON_STEPS];
    logic [32:0] r_y2 [NEWTON_STEPS];
    logic [31:0] r_yb [NEWTON_STEPS];
    logic [31:0] r_f  [NEWTON_STEPS];
    logic [31:0] r_yc [NEWTON_STEPS];

    for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_newton
        localparam int A = ST_NEWT + 3 * j;
        logic [31:0] w_yin;
        logic [63:0] w_yy;
        logic [64:0] w_mt;
        logic [32:0] w_t;
        logic [63:0] w_yf;

        if (j == 0) begin : g_seed
            assign w_yin = qrm_pkg::SEED_Q30;
        end else begin : g_chain
            assign w_yin = r_yc[j-1];
        end

        assign w_yy = 64'(w_yin) * 64'(w_yin);
        assign w_mt = 65'(r_car[A].m) * 65'(r_y2[j]);
        assign w_t  = w_mt[64:32];
        assign w_yf = 64'(r_yb[j]) * 64'(r_f[j]);

        always_ff @(posedge i_clk) begin
            if (w_en[A]) begin
                r_ya[j] <= w_yin;
                r_y2[j] <= w_yy[62:30];
            end
            if (w_en[A+1]) begin
                r_yb[j] <= r_ya[j];
                r_f[j]  <= (w_t < qrm_pkg::THREE_Q30) ?
                           32'(qrm_pkg::THREE_Q30 - w_t) : '0;
            end
            if (w_en[A+2]) begin
                r_yc[j] <= w_yf[62:31];
            end
        end
    end

    // scale component magnitudes by the inverse square root
    logic [48:0] r_pm [4];

    for (genvar i = 0; i < 4; i++) begin : g_nmul
        logic signed [16:0] w_qe;
        logic [16:0]        w_mag;
        assign w_qe  = 17'($signed(r_car[ST_NMUL-1].q[i]));
        assign w_mag = w_qe[16] ? 17'(-w_qe) : 17'(w_qe);

        always_ff @(posedge i_clk) begin
            if (w_en[ST_NMUL]) begin
                r_pm[i] <= 49'(w_mag) * 49'(r_yc[NEWTON_STEPS-1]);
            end
        end
    end

    // shift down and restore sign: Q2.30 components
    logic signed [31:0] r_n [4];
    logic               r_id_s;

    for (genvar i = 0; i < 4; i++) begin : g_nsh
        logic [31:0] w_r;
        assign w_r = 32'(r_pm[i] >> r_car[ST_NMUL].sh);

        always_ff @(posedge i_clk) begin
            if (w_en[ST_NSH]) begin
                r_n[i] <= r_car[ST_NMUL].q[i][15] ? -$signed(w_r) : $signed(w_r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NSH]) begin
            r_id_s <= r_car[ST_NMUL].ident;
        end
    end

    // products: xx yy zz xy xz yz wx wy wz
    logic signed [63:0] r_pr [9];
    logic               r_id_p;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_pr[0] <= r_n[0] * r_n[0];
            r_pr[1] <= r_n[1] * r_n[1];
            r_pr[2] <= r_n[2] * r_n[2];
            r_pr[3] <= r_n[0] * r_n[1];
            r_pr[4] <= r_n[0] * r_n[2];
            r_pr[5] <= r_n[1] * r_n[2];
            r_pr[6] <= r_n[3] * r_n[0];
            r_pr[7] <= r_n[3] * r_n[1];
            r_pr[8] <= r_n[3] * r_n[2];
            r_id_p  <= r_id_s;
        end
    end

    // matrix entries in Q60
    logic signed [65:0] r_e [9];
    logic               r_id_e;
    logic signed [65:0] w_xx, w_yy2, w_zz, w_xy, w_xz, w_yz, w_wx, w_wy, w_wz;

    assign w_xx  = 66'(r_pr[0]);
    assign w_yy2 = 66'(r_pr[1]);
    assign w_zz  = 66'(r_pr[2]);
    assign w_xy  = 66'(r_pr[3]);
    assign w_xz  = 66'(r_pr[4]);
    assign w_yz  = 66'(r_pr[5]);
    assign w_wx  = 66'(r_pr[6]);
    assign w_wy  = 66'(r_pr[7]);
    assign w_wz  = 66'(r_pr[8]);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_e[0] <= qrm_pkg::ONE_Q60 - ((w_yy2 + w_zz) <<< 1);
            r_e[1] <= (w_xy + w_wz) <<< 1;
            r_e[2] <= (w_xz - w_wy) <<< 1;
            r_e[3] <= (w_xy - w_wz) <<< 1;
            r_e[4] <= qrm_pkg::ONE_Q60 - ((w_xx + w_zz) <<< 1);
            r_e[5] <= (w_yz + w_wx) <<< 1;
            r_e[6] <= (w_xz + w_wy) <<< 1;
            r_e[7] <= (w_yz - w_wx) <<< 1;
            r_e[8] <= qrm_pkg::ONE_Q60 - ((w_xx + w_yy2) <<< 1);
            r_id_e <= r_id_p;
        end
    end

    // output register: round, saturate, substitute identity
    logic [8:0][15:0] r_dat;
    logic             r_usr;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            for (int i = 0; i < 9; i++) begin
                if (r_id_e) begin
                    r_dat[i] <= (i == 0 || i == 4 || i == 8) ? qrm_pkg::ONE_Q14 : '0;
                end else begin
                    r_dat[i] <= qrm_pkg::round_sat(r_e[i]);
                end
            end
            r_usr <= r_id_e;
        end
    end

    assign m_axis_tdata = r_dat;
    assign m_axis_tuser = r_usr;

    `QRM_ASSERT_NXT(a_accept_fills_entry, s_axis_tvalid && s_axis_tready && i_rst_n, r_v[0])
    `QRM_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, &r_v)
    `QRM_ASSERT_IMP(a_identity_diag, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:0] == qrm_pkg::ONE_Q14 && m_axis_tdata[31:16] == 16'd0)
    `QRM_ASSERT_NXT(a_cfg_write, i_cfg_we && i_rst_n, r_tol == $past(i_cfg_wdata))

endmodule

[verif/tb_quaternion_to_rotation_matrix_top.sv]
module tb_quaternion_to_rotation_matrix_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 9 + 3 * qrm_pkg::NEWTON_STEPS;

    typedef struct packed {
        logic [8:0][15:0] entries;   // row-major, entry 0 in the low bits
        logic             ident;
    } t_rot;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // row0_col0 ... row2_col2
    logic         m_axis_tuser;   // used_identity

    quaternion_to_rotation_matrix_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [31:0] tolerance;
    t_rot        expected_rots[$];
    int          error_count;
    int          quat_count;
    int          matrix_count;
    int          identity_count;
    bit          drain_random;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_quaternion_to_rotation_matrix_top: FAIL");
        $finish;
    end

    // inverse square root of a mantissa in [2^30, 2^32), Q2.30
    function automatic logic [63:0] inv_sqrt(input logic [63:0] mant);
        logic [63:0] y, y2, t, f;
        y = 64'(qrm_pkg::SEED_Q30);
        for (int i = 0; i < qrm_pkg::NEWTON_STEPS; i++) begin
            y2 = (y * y) >> 30;
            t  = (mant * y2) >> 32;
            f  = (t < 64'(qrm_pkg::THREE_Q30)) ? 64'(qrm_pkg::THREE_Q30) - t : 64'd0;
            y  = (y * f) >> 31;
        end
        return y;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [127:0] v);
        logic signed [127:0] r;
        r = (v + (128'sd1 <<< 45)) >>> 46;
        if (r > 128'sd32767) return 16'sh7fff;
        if (r < -128'sd32768) return 16'sh8000;
        return 16'(r);
    endfunction

    function automatic t_rot rotation_of(input logic [63:0] quat);
        t_rot                r;
        logic signed [15:0]  c[4];
        logic signed [127:0] n[4];
        logic signed [127:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
        logic [63:0]         len, mant, inv, mag;
        int                  s;
        for (int i = 0; i < 4; i++) c[i] = quat[16*i +: 16];
        len = 0;
        for (int i = 0; i < 4; i++) len += 64'(int'(c[i]) * int'(c[i]));
        if (len <= {32'd0, tolerance}) begin
            r.entries = '0;
            r.entries[0] = qrm_pkg::ONE_Q14;
            r.entries[4] = qrm_pkg::ONE_Q14;
            r.entries[8] = qrm_pkg::ONE_Q14;
            r.ident = 1'b1;
            return r;
        end
        mant = len;
        s = 0;
        while (mant < (64'd1 << 30)) begin
            mant <<= 2;
            s += 2;
        end
        while (mant >= (64'd1 << 32)) begin
            mant >>= 2;
            s -= 2;
        end
        inv = inv_sqrt(mant);
        for (int i = 0; i < 4; i++) begin
            mag  = 64'(c[i] < 0 ? -int'(c[i]) : int'(c[i]));
            n[i] = 128'((mag * inv) >> (16 - s / 2));
            if (c[i] < 0) n[i] = -n[i];
        end
        xx = n[0] * n[0]; yy = n[1] * n[1]; zz = n[2] * n[2];
        xy = n[0] * n[1]; xz = n[0] * n[2]; yz = n[1] * n[2];
        wx = n[3] * n[0]; wy = n[3] * n[1]; wz = n[3] * n[2];
        one = 128'sd1 <<< 60;
        r.entries[0] = to_q14(one - 2 * (yy + zz));
        r.entries[1] = to_q14(2 * (xy + wz));
        r.entries[2] = to_q14(2 * (xz - wy));
        r.entries[3] = to_q14(2 * (xy - wz));
        r.entries[4] = to_q14(one - 2 * (xx + zz));
        r.entries[5] = to_q14(2 * (yz + wx));
        r.entries[6] = to_q14(2 * (xz + wy));
        r.entries[7] = to_q14(2 * (yz - wx));
        r.entries[8] = to_q14(one - 2 * (xx + yy));
        r.ident = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        $display("mismatch %0s: got %0d, expected %0d (matrix %0d)", what,
                 $signed(got), $signed(want), matrix_count);
    endtask

    // output side: compare each transaction with the oldest expectation; while
    // drain_random is set, hold ready low for a random number of cycles at times
    initial begin
        int   hold;
        t_rot want;
        m_axis_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rots.size() == 0) begin
                    report_mismatch("unexpected matrix", m_axis_tdata[15:0], 16'd0);
                end else begin
                    want = expected_rots.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_axis_tdata[16*i +: 16] !== want.entries[i])
                            report_mismatch($sformatf("entry %0d", i),
                                            m_axis_tdata[16*i +: 16], want.entries[i]);
                    if (m_axis_tuser !== want.ident)
                        report_mismatch("used_identity", 16'(m_axis_tuser), 16'(want.ident));
                end
                matrix_count++;
                hold = drain_random ? $urandom_range(0, 7) : 0;
                if ((matrix_count / 200) % 3 == 2) hold = 0;
                if (hold > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // called at a rising edge; returns at the edge that accepts the transaction
    // with tvalid still high, so a following call can go back to back
    task automatic send_quat(input logic [63:0] quat, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if ((quat_count / 150) % 3 == 1) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= quat;
        expected_rots.push_back(rotation_of(quat));
        if (rotation_of(quat).ident) identity_count++;
        quat_count++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_rots.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [31:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tolerance = value;
    endtask

    function automatic logic [63:0] pack_quat(input int x, input int y, input int z,
                                              input int w);
        return {16'(w), 16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic test_edge_quats();
        send_quat(pack_quat(0, 0, 0, 0), 1'b0);
        send_quat(pack_quat(0, 0, 0, 4096), 1'b0);
        send_quat(pack_quat(4096, 0, 0, 0), 1'b0);
        send_quat(pack_quat(0, 4096, 0, 0), 1'b0);
        send_quat(pack_quat(0, 0, 4096, 0), 1'b0);
        send_quat(pack_quat(-32768, -32768, -32768, -32768), 1'b0);
        send_quat(pack_quat(32767, 32767, 32767, 32767), 1'b0);
        send_quat(pack_quat(32767, -32768, 32767, -32768), 1'b0);
        send_quat(pack_quat(1, 0, 0, 0), 1'b0);
        send_quat(pack_quat(0, 0, 0, -1), 1'b0);
        send_quat(pack_quat(1, 1, 1, 1), 1'b0);
        send_quat(pack_quat(-32768, 0, 0, 0), 1'b0);
        send_quat(pack_quat(2896, 2896, 0, 0), 1'b0);
        send_quat(pack_quat(2048, 2048, 2048, 2048), 1'b0);
        send_quat(pack_quat(-2048, 2048, -2048, 2048), 1'b0);
        send_quat(pack_quat(3, -5, 7, -11), 1'b0);
    endtask

    task automatic test_tolerance_edges();
        write_tolerance(32'd4);
        send_quat(pack_quat(1, 1, 1, 1), 1'b0);      // length equals tolerance
        send_quat(pack_quat(2, 1, 0, 0), 1'b0);      // one above
        write_tolerance(32'hffff_ffff);
        send_quat(pack_quat(32767, 32767, 32767, 32767), 1'b0);
        send_quat(pack_quat(-32768, -32768, -32768, -32768), 1'b0);
        send_quat(pack_quat(-32768, -32768, -32768, -32767), 1'b0);
        write_tolerance(32'd0);
    endtask

    task automatic test_random(input int count);
        int   mode;
        logic [63:0] q;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            q = {$urandom, $urandom};
            // half with components in [-4096, 4096], some tiny, some extreme, rest random
            if (mode < 5) begin
                for (int i = 0; i < 4; i++) q[16*i +: 16] = 16'($signed(
                    $urandom_range(0, 8192)) - 4096);
            end else if (mode == 5) begin
                for (int i = 0; i < 4; i++) q[16*i +: 16] = 16'($signed(
                    $urandom_range(0, 16)) - 8);
            end else if (mode == 6) begin
                for (int i = 0; i < 4; i++)
                    q[16*i +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            end
            send_quat(q, 1'b1);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tolerance     = '0;
        error_count   = 0;
        quat_count    = 0;
        matrix_count  = 0;
        identity_count = 0;
        drain_random  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_quats();
        test_tolerance_edges();
        drain_random = 1'b1;
        test_random(500);
        // hold off until the pipe has fully drained
        wait_drained();
        write_tolerance(32'd16777216);
        test_random(400);
        write_tolerance($urandom);
        test_random(100);
        write_tolerance(32'd4096);
        test_random(400);

        wait_drained();
        $display("%0d quaternions converted, %0d matrices checked, %0d via identity",
                 quat_count, matrix_count, identity_count);
        $display("tolerance swept from 0 to all ones with random stalls on both sides");
        if (error_count == 0 && expected_rots.size() == 0) begin
            $display("tb_quaternion_to_rotation_matrix_top: PASS");
        end else begin
            $display("tb_quaternion_to_rotation_matrix_top: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/qrm_pkg.sv
hdl/quaternion_to_rotation_matrix_top.sv
verif/tb_quaternion_to_rotation_matrix_top.sv
